FILE: sv/fsk_id_deframer_unit_macros.svh
// assertion macros used by the checker file
`ifndef FSK_ID_DEFRAMER_UNIT_MACROS_SVH
`define FSK_ID_DEFRAMER_UNIT_MACROS_SVH

// checked only while reset is low
`define FSKID_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define FSKID_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/fskid_pkg.sv
package fskid_pkg;

   localparam int HISTORY_BITS = 24;
   localparam int CHAR_BITS    = 6;
   localparam int POWER_WIDTH  = 32;
   localparam int SYNC_GROUPS  = 2;
   localparam int TEST_BITS    = HISTORY_BITS / 2;

   localparam logic [CHAR_BITS-1:0] SYNC_FIRST   = 6'h20;
   localparam logic [CHAR_BITS-1:0] SYNC_SECOND  = 6'h2A;
   localparam logic [6:0]           ASCII_OFFSET = 7'h20;

   localparam logic [7:0] SEARCH_LIMIT_RST  = 8'd177;
   localparam logic [3:0] MAX_CHARS_RST     = 4'd10;
   localparam logic [5:0] END_THRESHOLD_RST = 6'd13;

   localparam logic [1:0] CSR_SEARCH_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_MAX_CHARS     = 2'd1;
   localparam logic [1:0] CSR_END_THRESHOLD = 2'd2;

   localparam logic [1:0] ST_RUNNING    = 2'd0;
   localparam logic [1:0] ST_TERMINATOR = 2'd1;
   localparam logic [1:0] ST_LENGTH     = 2'd2;
   localparam logic [1:0] ST_NO_SYNC    = 2'd3;

   localparam logic REQ_WINDOW  = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   typedef struct packed {
      logic                   req_type;
      logic [POWER_WIDTH-1:0] lo_power;
      logic [POWER_WIDTH-1:0] hi_power;
   } req_payload_type;

   typedef struct packed {
      logic       char_valid;
      logic [6:0] char_code;
      logic       in_sync;
      logic       done_res;
      logic [1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] search_limit;
      logic [3:0] max_chars;
      logic [5:0] end_threshold;
   } cfg_type;

   typedef struct packed {
      logic [HISTORY_BITS-1:0] bit_history;
      logic                    synced;
      logic [7:0]              windows_tested;
      logic [2:0]              bit_position;
      logic [CHAR_BITS-1:0]    char_accum;
      logic [3:0]              chars_sent;
      logic                    finished;
      logic [1:0]              end_status;
   } state_type;

   function automatic logic [CHAR_BITS-1:0] rev_char(input logic [CHAR_BITS-1:0] x);
      logic [CHAR_BITS-1:0] r;
      r = '0;
      for (int k = 0; k < CHAR_BITS; k++) begin
         r[CHAR_BITS-1-k] = x[k];
      end
      return r;
   endfunction

   // every other older bit, oldest first, as two reversed groups
   function automatic logic sync_match(input logic [HISTORY_BITS-1:0] hist);
      logic [TEST_BITS-1:0] test;
      test = '0;
      for (int i = 0; i < TEST_BITS; i++) begin
         test[TEST_BITS-1-i] = hist[HISTORY_BITS-1-2*i];
      end
      return (rev_char(test[2*CHAR_BITS-1:CHAR_BITS]) == SYNC_FIRST) &&
             (rev_char(test[CHAR_BITS-1:0]) == SYNC_SECOND);
   endfunction

endpackage

FILE: sv/fskid_step.sv
module fskid_step (
   input  fskid_pkg::state_type       state,
   input  fskid_pkg::cfg_type         cfg,
   input  fskid_pkg::req_payload_type req,
   output fskid_pkg::state_type       state_in,
   output fskid_pkg::rsp_payload_type rsp
);

   logic                              win_bit;
   logic [fskid_pkg::HISTORY_BITS-1:0] hist;
   logic [7:0]                        windows;
   logic [fskid_pkg::CHAR_BITS-1:0]   accum;
   logic [2:0]                        pos;

   assign win_bit = req.lo_power > req.hi_power;
   assign hist    = {state.bit_history[fskid_pkg::HISTORY_BITS-2:0], win_bit};
   assign windows = state.windows_tested + 8'd1;
   assign accum   = state.char_accum |
                    (fskid_pkg::CHAR_BITS'({5'd0, win_bit}) << state.bit_position);
   assign pos     = state.bit_position + 3'd1;

   always_comb begin
      state_in = state;
      rsp      = '0;
      if (req.req_type == fskid_pkg::REQ_RESTART) begin
         state_in = '0;
      end else if (!state.finished) begin
         if (!state.synced) begin
            state_in.bit_history    = hist;
            state_in.windows_tested = windows;
            if (fskid_pkg::sync_match(hist)) begin
               state_in.synced       = 1'b1;
               state_in.char_accum   = '0;
               state_in.bit_position = '0;
               state_in.chars_sent   = '0;
            end else if (windows >= cfg.search_limit || windows == 8'd0) begin
               state_in.finished   = 1'b1;
               state_in.end_status = fskid_pkg::ST_NO_SYNC;
            end
         end else begin
            state_in.char_accum   = accum;
            state_in.bit_position = pos;
            if (pos >= 3'(fskid_pkg::CHAR_BITS)) begin
               if (accum < cfg.end_threshold) begin
                  state_in.finished   = 1'b1;
                  state_in.end_status = fskid_pkg::ST_TERMINATOR;
               end else if (state.chars_sent >= cfg.max_chars) begin
                  state_in.finished   = 1'b1;
                  state_in.end_status = fskid_pkg::ST_LENGTH;
               end else begin
                  rsp.char_valid      = 1'b1;
                  rsp.char_code       = {1'b0, accum} + fskid_pkg::ASCII_OFFSET;
                  state_in.chars_sent = state.chars_sent + 4'd1;
               end
               state_in.bit_position = '0;
               state_in.char_accum   = '0;
            end
         end
      end
      rsp.in_sync  = state_in.synced;
      rsp.done_res = state_in.finished;
      rsp.status   = state_in.finished ? state_in.end_status : fskid_pkg::ST_RUNNING;
   end

endmodule

FILE: sv/fsk_id_deframer_unit.sv
// FSK ident deframer. Each request carries the 1900 Hz and 2100 Hz tone powers of one
// analysis window (or a restart), and yields exactly one response: a new ASCII character
// when one completes, plus sync, done and end status. Throughput is one request per clock
// while the response output is not stalled. A request passes an input register and the
// state update into the response register. The user must write the registers on csr_ only
// while no request is in flight; the block does not enforce this. csr_ready is always high.
module fsk_id_deframer_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fskid_pkg::req_payload_type  req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fskid_pkg::rsp_payload_type  rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [7:0]                  csr_wdata
);

   logic                       req_vld_ff;
   fskid_pkg::req_payload_type req_ff;
   logic                       rsp_vld_ff;
   fskid_pkg::rsp_payload_type rsp_ff;
   fskid_pkg::rsp_payload_type rsp_in;
   fskid_pkg::state_type       state_ff;
   fskid_pkg::state_type       state_in;
   fskid_pkg::cfg_type         cfg_ff;
   logic                       advance;

   assign advance     = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall   = req_vld_ff && !advance;
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   fskid_step u_step (
      .state    (state_ff),
      .cfg      (cfg_ff),
      .req      (req_ff),
      .state_in (state_in),
      .rsp      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff           <= 1'b0;
         rsp_vld_ff           <= 1'b0;
         state_ff             <= '0;
         cfg_ff.search_limit  <= fskid_pkg::SEARCH_LIMIT_RST;
         cfg_ff.max_chars     <= fskid_pkg::MAX_CHARS_RST;
         cfg_ff.end_threshold <= fskid_pkg::END_THRESHOLD_RST;
      end else begin
         if (!req_stall) begin
            req_vld_ff <= req_valid;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
            state_ff   <= state_in;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               fskid_pkg::CSR_SEARCH_LIMIT:  cfg_ff.search_limit  <= csr_wdata;
               fskid_pkg::CSR_MAX_CHARS:     cfg_ff.max_chars     <= csr_wdata[3:0];
               fskid_pkg::CSR_END_THRESHOLD: cfg_ff.end_threshold <= csr_wdata[5:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: sv/fskid_checker.sv
`include "fsk_id_deframer_unit_macros.svh"

module fskid_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input fskid_pkg::rsp_payload_type rsp_payload
);

   `FSKID_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled response changed")
   `FSKID_ASSERT(a_char_in_run, clock, reset, rsp_valid && rsp_payload.char_valid |-> rsp_payload.in_sync && !rsp_payload.done_res, "character outside a synced run")
   `FSKID_ASSERT(a_status_running, clock, reset, rsp_valid && !rsp_payload.done_res |-> rsp_payload.status == fskid_pkg::ST_RUNNING, "end status while running")
   `FSKID_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response right after reset")

endmodule

bind fsk_id_deframer_unit fskid_checker u_fskid_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

FILE: tb/sv/tb_top.sv
module tb_top;
   import fskid_pkg::*;

   localparam logic [1:0] CSR_UNUSED     = 2'd3;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DRAIN_CYCLES   = 20;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid   = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index   = '0;
   logic [7:0]      csr_wdata   = '0;

   fsk_id_deframer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // register copies
   logic [7:0] lim_search  = SEARCH_LIMIT_RST;
   logic [3:0] lim_chars   = MAX_CHARS_RST;
   logic [5:0] term_thresh = END_THRESHOLD_RST;

   // deframer state copy
   logic [HISTORY_BITS-1:0] win_hist = '0;
   logic                    locked   = 1'b0;
   logic [7:0]              searched = '0;
   logic [2:0]              bitpos   = '0;
   logic [CHAR_BITS-1:0]    accum    = '0;
   logic [3:0]              nchars   = '0;
   logic                    ended    = 1'b0;
   logic [1:0]              end_code = ST_RUNNING;

   req_payload_type pending_reqs[$];
   rsp_payload_type expected_rsps[$];
   rsp_payload_type want;
   int              fail_count  = 0;
   int              queued_count = 0;
   int              idle_mode   = 1;
   int              gap_left    = 0;
   int              n_gap;
   int              stall_left  = 0;
   int              n_stall;
   int              idle_cycles = 0;

   function automatic rsp_payload_type predict_deframe(input req_payload_type r);
      rsp_payload_type      o;
      logic                 b;
      logic [11:0]          taps;
      logic [CHAR_BITS-1:0] grp_hi;
      logic [CHAR_BITS-1:0] grp_lo;
      int                   i;
      o = '0;
      if (r.req_type == REQ_RESTART) begin
         win_hist = '0;
         locked   = 1'b0;
         searched = '0;
         bitpos   = '0;
         accum    = '0;
         nchars   = '0;
         ended    = 1'b0;
         end_code = ST_RUNNING;
      end else if (!ended) begin
         b = (r.lo_power > r.hi_power);
         if (!locked) begin
            win_hist = {win_hist[HISTORY_BITS-2:0], b};
            for (i = 0; i < 12; i++) begin
               taps[11-i] = win_hist[HISTORY_BITS-1-2*i];
            end
            for (i = 0; i < CHAR_BITS; i++) begin
               grp_hi[CHAR_BITS-1-i] = taps[CHAR_BITS+i];
               grp_lo[CHAR_BITS-1-i] = taps[i];
            end
            searched = searched + 8'd1;
            if (grp_hi == SYNC_FIRST && grp_lo == SYNC_SECOND) begin
               locked = 1'b1;
               accum  = '0;
               bitpos = '0;
               nchars = '0;
            end else if (searched >= lim_search || searched == 8'd0) begin
               ended    = 1'b1;
               end_code = ST_NO_SYNC;
            end
         end else begin
            if (b) begin
               accum[bitpos] = 1'b1;
            end
            bitpos = bitpos + 3'd1;
            if (bitpos >= CHAR_BITS) begin
               if (accum < term_thresh) begin
                  ended    = 1'b1;
                  end_code = ST_TERMINATOR;
               end else if (nchars >= lim_chars) begin
                  ended    = 1'b1;
                  end_code = ST_LENGTH;
               end else begin
                  o.char_valid = 1'b1;
                  o.char_code  = {1'b0, accum} + ASCII_OFFSET;
                  nchars       = nchars + 4'd1;
               end
               bitpos = '0;
               accum  = '0;
            end
         end
      end
      o.in_sync  = locked;
      o.done_res = ended;
      o.status   = ended ? end_code : ST_RUNNING;
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_deframe(req_payload));
            n_gap = (idle_mode != 0) ? $urandom_range(0, 5) : 0;
            if (n_gap == 0 && pending_reqs.size() != 0) begin
               req_payload <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
               gap_left  <= (n_gap > 0) ? n_gap - 1 : 0;
            end
         end else if (!req_valid) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
               req_valid   <= 1'b1;
               req_payload <= pending_reqs.pop_front();
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response %h", rsp_payload);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.char_valid !== want.char_valid) begin
                  $error("char_valid expected %0d actual %0d",
                         want.char_valid, rsp_payload.char_valid);
                  fail_count++;
               end
               if (rsp_payload.char_code !== want.char_code) begin
                  $error("char_code expected %0h actual %0h",
                         want.char_code, rsp_payload.char_code);
                  fail_count++;
               end
               if (rsp_payload.in_sync !== want.in_sync) begin
                  $error("in_sync expected %0d actual %0d", want.in_sync, rsp_payload.in_sync);
                  fail_count++;
               end
               if (rsp_payload.done_res !== want.done_res) begin
                  $error("done_res expected %0d actual %0d",
                         want.done_res, rsp_payload.done_res);
                  fail_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_payload.status);
                  fail_count++;
               end
            end
            n_stall = (idle_mode != 0) ? $urandom_range(0, 5) : 0;
            stall_left <= n_stall;
            rsp_stall  <= (n_stall != 0);
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= (stall_left > 1);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic push_req(input logic t, input logic [POWER_WIDTH-1:0] lo,
                           input logic [POWER_WIDTH-1:0] hi);
      req_payload_type p;
      p.req_type = t;
      p.lo_power = lo;
      p.hi_power = hi;
      pending_reqs.push_back(p);
      queued_count++;
   endtask

   task automatic push_window(input logic b);
      logic [POWER_WIDTH-1:0] a;
      logic [POWER_WIDTH-1:0] c;
      a = POWER_WIDTH'($urandom);
      c = POWER_WIDTH'($urandom);
      case ($urandom_range(0, 7))
         0: c = a;
         1: begin
            a = '1;
            c = '0;
         end
         2: begin
            a = '1;
            c = '1;
            c[0] = 1'b0;
         end
         3: begin
            a = '0;
            c = '0;
         end
         default: ;
      endcase
      if (b) begin
         if (a == c) begin
            if (a == '0) push_req(REQ_WINDOW, POWER_WIDTH'(1), '0);
            else push_req(REQ_WINDOW, a, a - 1'b1);
         end else if (a > c) begin
            push_req(REQ_WINDOW, a, c);
         end else begin
            push_req(REQ_WINDOW, c, a);
         end
      end else begin
         if (a > c) push_req(REQ_WINDOW, c, a);
         else push_req(REQ_WINDOW, a, c);
      end
   endtask

   // sync bytes sent lsb first, two half-symbol windows per bit
   task automatic push_sync(input logic broken);
      logic [11:0] pattern;
      int          slip;
      int          j;
      pattern = {SYNC_SECOND, SYNC_FIRST};
      slip = broken ? int'($urandom_range(0, 23)) : -1;
      for (j = 0; j < 24; j++) begin
         push_window(pattern[j/2] ^ (j == slip));
      end
   endtask

   task automatic push_char(input logic [CHAR_BITS-1:0] ch);
      int k;
      for (k = 0; k < CHAR_BITS; k++) begin
         push_window(ch[k]);
      end
   endtask

   task automatic add_run();
      int                   kind;
      int                   nch;
      logic [CHAR_BITS-1:0] ch;
      if ($urandom_range(0, 9) != 0) begin
         push_req(REQ_RESTART, POWER_WIDTH'($urandom), POWER_WIDTH'($urandom));
      end
      kind = $urandom_range(0, 9);
      repeat ($urandom_range(0, 6)) push_window(1'($urandom_range(0, 1)));
      if (kind == 0) begin
         repeat ($urandom_range(5, 40)) push_window(1'($urandom_range(0, 1)));
      end else begin
         push_sync(kind == 1);
         nch = $urandom_range(0, 17);
         repeat (nch) begin
            ch = CHAR_BITS'($urandom_range(63, term_thresh));
            push_char(ch);
         end
         if (term_thresh != 0 && $urandom_range(0, 1) == 1) begin
            ch = CHAR_BITS'($urandom_range(term_thresh - 1, 0));
            push_char(ch);
         end
         repeat ($urandom_range(0, 2)) push_window(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SEARCH_LIMIT:  lim_search  = data;
         CSR_MAX_CHARS:     lim_chars   = data[3:0];
         CSR_END_THRESHOLD: term_thresh = data[5:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] sl, input logic [3:0] mc, input logic [5:0] et);
      logic [7:0] w;
      csr_write(CSR_SEARCH_LIMIT, sl);
      w = 8'($urandom);
      w[3:0] = mc;
      csr_write(CSR_MAX_CHARS, w);
      w = 8'($urandom);
      w[5:0] = et;
      csr_write(CSR_END_THRESHOLD, w);
      if ($urandom_range(0, 1) == 1) begin
         csr_write(CSR_UNUSED, 8'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   initial begin
      int ph;
      int target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // power extremes under reset settings
      push_req(REQ_WINDOW, '1, '0);
      push_req(REQ_WINDOW, '0, '1);
      push_req(REQ_WINDOW, '1, '1);
      push_req(REQ_WINDOW, '0, '0);
      push_req(REQ_WINDOW, '1, 32'hFFFF_FFFE);
      push_req(REQ_RESTART, '1, '1);
      wait_idle();

      // sync on the last search window, then terminator together with length limit
      set_config(8'd24, 4'd0, 6'd13);
      push_req(REQ_RESTART, '0, '0);
      push_sync(1'b0);
      push_char(6'd5);
      push_window(1'b1);
      wait_idle();

      // zero search limit
      set_config(8'd0, 4'd15, 6'd0);
      push_req(REQ_RESTART, '0, '1);
      push_window(1'b0);
      push_window(1'b1);
      wait_idle();

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_config(SEARCH_LIMIT_RST, MAX_CHARS_RST, END_THRESHOLD_RST);
            1: set_config(8'd255, 4'd15, 6'd63);
            2: set_config(8'd1, 4'd1, 6'd0);
            3: set_config(8'd255, 4'd15, 6'd0);
            4: set_config(8'd30, 4'd0, 6'd20);
            default: set_config(8'($urandom_range(24, 255)), 4'($urandom_range(0, 15)),
                                6'($urandom_range(0, 63)));
         endcase
         idle_mode = (ph % 3 == 1) ? 0 : 1;
         target = queued_count + 135;
         while (queued_count < target) add_run();
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/fskid_pkg.sv
sv/fskid_step.sv
sv/fsk_id_deframer_unit.sv
sv/fskid_checker.sv
tb/sv/tb_top.sv
